@@ hdl/pcp_pkg.sv @@
package pcp_pkg;

  localparam int COORD_W          = 24;
  localparam int IDX_W            = 10;
  localparam int DIFF_W           = COORD_W + 1;
  localparam int MUL_W            = COORD_W + 2;
  localparam int ACC_W            = 2 * MUL_W;
  localparam int MAX_VERTICES_DEF = 1024;
  localparam int FRAC_BITS_DEF    = 16;

endpackage

@@ hdl/pcp_div.sv @@
module pcp_div import pcp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [ACC_W-1:0]     num,
  input  logic [ACC_W-1:0]     den,
  output logic                 done,
  output logic [FRAC_BITS-1:0] quo
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [ACC_W-1:0]     rem_r;
  logic [ACC_W-1:0]     den_r;
  logic [FRAC_BITS-1:0] quo_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 done_r;
  logic [ACC_W-1:0]     shifted;
  logic [ACC_W-1:0]     diff;
  logic                 ge;

  // One restoring step per cycle; the remainder stays below the divisor.
  assign shifted = {rem_r[ACC_W-2:0], 1'b0};
  assign ge      = (shifted >= den_r);
  assign diff    = shifted - den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= num;
        den_r <= den;
        quo_r <= '0;
        cnt_r <= CNT_W'(FRAC_BITS);
      end else if (cnt_r != '0) begin
        rem_r  <= ge ? diff : shifted;
        quo_r  <= {quo_r[FRAC_BITS-2:0], ge};
        cnt_r  <= cnt_r - CNT_W'(1);
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ hdl/polyline_closest_point_top.sv @@
// A vertex that closes a segment occupies the block through its difference, multiply and
// accumulate steps, and the divider unless t clamps. One shared 26x26 multiplier forms each
// product in a multiply and an accumulate step; a restoring divider retires one quotient bit
// per cycle. Queries and vertices closing no segment are taken in the idle state. A last vertex
// loads the result register in the emit step when the output is free. Reset is synchronous,
// active low, and clears the control, count, best and output-valid state with no clearing pass.
module polyline_closest_point_top import pcp_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_func,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_z,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_found,
  output logic [IDX_W-1:0]          out_seg_index,
  output logic signed [COORD_W-1:0] out_near_x,
  output logic signed [COORD_W-1:0] out_near_z
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int T_W   = FRAC_BITS + 1;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIFF  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_ACC   = 8'b0000_1000,
    S_TSEL  = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_DELTA = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    OP_LEN_X, OP_LEN_Z, OP_DOT_X, OP_DOT_Z,
    OP_NEAR_X, OP_NEAR_Z, OP_DIST_X, OP_DIST_Z
  } op_t;

  state_t                     state_r;
  op_t                        op_r;
  logic signed [COORD_W-1:0]  query_x_r, query_z_r;
  logic signed [COORD_W-1:0]  prev_x_r, prev_z_r;
  logic signed [COORD_W-1:0]  cur_x_r, cur_z_r;
  logic                       cur_last_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [ACC_W-1:0]           best_dist_r;
  logic [CNT_W-1:0]           best_idx_r;
  logic signed [COORD_W-1:0]  best_x_r, best_z_r;
  logic                       have_best_r;
  logic signed [DIFF_W-1:0]   abx_r, abz_r, apx_r, apz_r, dx_r, dz_r;
  logic [T_W-1:0]             t_r;
  logic signed [ACC_W-1:0]    prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [ACC_W-1:0]           len_r;
  logic signed [ACC_W-1:0]    dot_r;
  logic signed [COORD_W-1:0]  near_x_r, near_z_r;
  logic                       out_valid_r;
  logic                       out_found_r;
  logic [IDX_W-1:0]           out_seg_index_r;
  logic signed [COORD_W-1:0]  out_near_x_r, out_near_z_r;

  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [ACC_W-1:0]    sum;
  logic signed [ACC_W-1:0]    prod_sh;
  logic signed [COORD_W-1:0]  near_calc;
  logic [CNT_W+IDX_W-1:0]     idx_ext;
  logic                       in_acc;
  logic                       out_free;
  logic                       t_zero;
  logic                       t_full;
  logic                       div_start;
  logic                       div_done;
  logic [FRAC_BITS-1:0]       div_q;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (op_r)
      OP_LEN_X: begin
        mul_a = {abx_r[DIFF_W-1], abx_r};
        mul_b = {abx_r[DIFF_W-1], abx_r};
      end
      OP_LEN_Z: begin
        mul_a = {abz_r[DIFF_W-1], abz_r};
        mul_b = {abz_r[DIFF_W-1], abz_r};
      end
      OP_DOT_X: begin
        mul_a = {apx_r[DIFF_W-1], apx_r};
        mul_b = {abx_r[DIFF_W-1], abx_r};
      end
      OP_DOT_Z: begin
        mul_a = {apz_r[DIFF_W-1], apz_r};
        mul_b = {abz_r[DIFF_W-1], abz_r};
      end
      OP_NEAR_X: begin
        mul_a = {abx_r[DIFF_W-1], abx_r};
        mul_b = signed'({{(MUL_W-T_W){1'b0}}, t_r});
      end
      OP_NEAR_Z: begin
        mul_a = {abz_r[DIFF_W-1], abz_r};
        mul_b = signed'({{(MUL_W-T_W){1'b0}}, t_r});
      end
      OP_DIST_X: begin
        mul_a = {dx_r[DIFF_W-1], dx_r};
        mul_b = {dx_r[DIFF_W-1], dx_r};
      end
      default: begin
        mul_a = {dz_r[DIFF_W-1], dz_r};
        mul_b = {dz_r[DIFF_W-1], dz_r};
      end
    endcase
  end

  assign sum     = acc_r + prod_r;
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign near_calc = (op_r == OP_NEAR_X) ? prev_x_r + prod_sh[COORD_W-1:0]
                                         : prev_z_r + prod_sh[COORD_W-1:0];
  assign idx_ext = {{IDX_W{1'b0}}, best_idx_r};

  assign t_zero = (len_r == '0) || dot_r[ACC_W-1] || (dot_r == '0);
  assign t_full = (unsigned'(dot_r) >= len_r);
  assign div_start = (state_r == S_TSEL) && !t_zero && !t_full;

  pcp_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (unsigned'(dot_r)),
    .den   (len_r),
    .done  (div_done),
    .quo   (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_LEN_X;
      query_x_r   <= '0;
      query_z_r   <= '0;
      prev_x_r    <= '0;
      prev_z_r    <= '0;
      cnt_r       <= '0;
      best_dist_r <= '1;
      best_idx_r  <= '0;
      best_x_r    <= '0;
      best_z_r    <= '0;
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cur_x_r    <= in_x;
            cur_z_r    <= in_z;
            cur_last_r <= in_last;
            if (!in_func) begin
              query_x_r   <= in_x;
              query_z_r   <= in_z;
              cnt_r       <= '0;
              best_dist_r <= '1;
              best_idx_r  <= '0;
              best_x_r    <= '0;
              best_z_r    <= '0;
              have_best_r <= 1'b0;
            end else if (cnt_r < CNT_W'(MAX_VERTICES) && cnt_r != '0) begin
              state_r <= S_DIFF;
            end else begin
              if (cnt_r < CNT_W'(MAX_VERTICES)) begin
                prev_x_r <= in_x;
                prev_z_r <= in_z;
                cnt_r    <= cnt_r + CNT_W'(1);
              end
              if (in_last) begin
                state_r <= S_EMIT;
              end
            end
          end
        end
        S_DIFF: begin
          abx_r   <= DIFF_W'(cur_x_r) - DIFF_W'(prev_x_r);
          abz_r   <= DIFF_W'(cur_z_r) - DIFF_W'(prev_z_r);
          apx_r   <= DIFF_W'(query_x_r) - DIFF_W'(prev_x_r);
          apz_r   <= DIFF_W'(query_z_r) - DIFF_W'(prev_z_r);
          op_r    <= OP_LEN_X;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_ACC;
        end
        S_ACC: begin
          op_r    <= op_t'(op_r + 3'd1);
          state_r <= S_MUL;
          case (op_r)
            OP_LEN_X, OP_DOT_X, OP_DIST_X: begin
              acc_r <= prod_r;
            end
            OP_LEN_Z: begin
              len_r <= unsigned'(sum);
            end
            OP_DOT_Z: begin
              dot_r   <= sum;
              state_r <= S_TSEL;
            end
            OP_NEAR_X: begin
              near_x_r <= near_calc;
            end
            OP_NEAR_Z: begin
              near_z_r <= near_calc;
              state_r  <= S_DELTA;
            end
            default: begin
              if (unsigned'(sum) < best_dist_r) begin
                best_dist_r <= unsigned'(sum);
                best_idx_r  <= cnt_r - CNT_W'(1);
                best_x_r    <= near_x_r;
                best_z_r    <= near_z_r;
                have_best_r <= 1'b1;
              end
              prev_x_r <= cur_x_r;
              prev_z_r <= cur_z_r;
              cnt_r    <= cnt_r + CNT_W'(1);
              state_r  <= cur_last_r ? S_EMIT : S_IDLE;
            end
          endcase
        end
        S_TSEL: begin
          if (t_zero) begin
            t_r     <= '0;
            state_r <= S_MUL;
          end else if (t_full) begin
            t_r     <= {1'b1, {FRAC_BITS{1'b0}}};
            state_r <= S_MUL;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            t_r     <= {1'b0, div_q};
            state_r <= S_MUL;
          end
        end
        S_DELTA: begin
          dx_r    <= DIFF_W'(query_x_r) - DIFF_W'(near_x_r);
          dz_r    <= DIFF_W'(query_z_r) - DIFF_W'(near_z_r);
          state_r <= S_MUL;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_found_r     <= have_best_r;
            out_seg_index_r <= idx_ext[IDX_W-1:0];
            out_near_x_r    <= best_x_r;
            out_near_z_r    <= best_z_r;
            cnt_r           <= '0;
            best_dist_r     <= '1;
            best_idx_r      <= '0;
            best_x_r        <= '0;
            best_z_r        <= '0;
            have_best_r     <= 1'b0;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_seg_index = out_seg_index_r;
  assign out_near_x    = out_near_x_r;
  assign out_near_z    = out_near_z_r;

`ifndef SYNTH
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result appeared outside the emit step");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished while the sequencer was not waiting");

  a_best_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    have_best_r |-> (best_dist_r != '1))
    else $error("best segment flagged without a recorded distance");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count exceeded its maximum");
`endif

endmodule
